FILE: rtl/dtq_pkg.sv
// dtq_pkg: word types and constants shared by the direction cosine matrix to
// quaternion pipeline. No dependencies.
package dtq_pkg;

    // fixed-point format, chain lengths and lane count
    localparam int QFrac     = 14;
    localparam int SqrtSteps = 16;
    localparam int DivSteps  = 30;
    localparam int Lanes     = 3;

    // branch codes
    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    // input word: one matrix
    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } in_word_t;

    // output word: one quaternion
    typedef struct packed {
        logic signed [15:0] scalar_part;
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
        logic [1:0]         branch_used;
        logic               degenerate;
    } out_word_t;

    // numerators and branch, carried along the chain
    typedef struct packed {
        logic [1:0]              branch;
        logic [Lanes-1:0]        neg;
        logic [Lanes-1:0][16:0]  mag;
    } ctx_t;

    // square root cell word
    typedef struct packed {
        ctx_t        ctx;
        logic [31:0] n;
        logic [17:0] rem;
        logic [15:0] root;
    } sqrt_t;

    // divider cell word
    typedef struct packed {
        logic [1:0]             branch;
        logic [Lanes-1:0]       neg;
        logic [15:0]            root;
        logic [Lanes-1:0][29:0] dvd;
        logic [Lanes-1:0][15:0] rem;
        logic [Lanes-1:0][29:0] quo;
    } div_t;

endpackage

FILE: rtl/dtq_front.sv
// dtq_front: branch choice, radicand and numerators, first pipeline stage.
// Depends on dtq_pkg.
module dtq_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dtq_pkg::in_word_t in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output dtq_pkg::sqrt_t   out_word
);

    logic              valid_reg;
    dtq_pkg::sqrt_t    word_reg;
    dtq_pkg::sqrt_t    word_next;

    logic signed [17:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [17:0] tr;
    logic signed [18:0] rad;
    logic [16:0]        rad_c;
    logic [1:0]         branch;
    logic signed [17:0] num0, num1, num2;

    // sign-extend elements
    assign m00 = 18'(in_word.r00);
    assign m01 = 18'(in_word.r01);
    assign m02 = 18'(in_word.r02);
    assign m10 = 18'(in_word.r10);
    assign m11 = 18'(in_word.r11);
    assign m12 = 18'(in_word.r12);
    assign m20 = 18'(in_word.r20);
    assign m21 = 18'(in_word.r21);
    assign m22 = 18'(in_word.r22);
    assign tr  = m00 + m11 + m22;

    // branch select, radicand and numerators
    always_comb
    begin
        if (tr > 18'sd0)
        begin
            branch = dtq_pkg::BR_TRACE;
            rad    = 19'(tr) + 19'sd16384;
            num0   = m21 - m12;
            num1   = m02 - m20;
            num2   = m10 - m01;
        end
        else if (m00 > m11 && m00 > m22)
        begin
            branch = dtq_pkg::BR_X;
            rad    = 19'sd16384 + 19'(m00) - 19'(m11) - 19'(m22);
            num0   = m21 - m12;
            num1   = m01 + m10;
            num2   = m02 + m20;
        end
        else if (m11 > m22)
        begin
            branch = dtq_pkg::BR_Y;
            rad    = 19'sd16384 + 19'(m11) - 19'(m00) - 19'(m22);
            num0   = m02 - m20;
            num1   = m01 + m10;
            num2   = m12 + m21;
        end
        else
        begin
            branch = dtq_pkg::BR_Z;
            rad    = 19'sd16384 + 19'(m22) - 19'(m00) - 19'(m11);
            num0   = m10 - m01;
            num1   = m02 + m20;
            num2   = m12 + m21;
        end
    end

    // clamp negative radicand
    assign rad_c = rad[18] ? 17'd0 : rad[16:0];

    // build the first cell word
    always_comb
    begin
        word_next.ctx.branch = branch;
        word_next.ctx.neg[0] = num0[17];
        word_next.ctx.neg[1] = num1[17];
        word_next.ctx.neg[2] = num2[17];
        word_next.ctx.mag[0] = num0[17] ? 17'(-num0) : num0[16:0];
        word_next.ctx.mag[1] = num1[17] ? 17'(-num1) : num1[16:0];
        word_next.ctx.mag[2] = num2[17] ? 17'(-num2) : num2[16:0];
        word_next.n          = {1'b0, rad_c, {dtq_pkg::QFrac{1'b0}}};
        word_next.rem        = '0;
        word_next.root       = '0;
    end

    assign in_ready = !valid_reg || out_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

FILE: rtl/dtq_sqrt_cell.sv
// dtq_sqrt_cell: one root digit per cell, radicand shifts two bits per cell.
// Depends on dtq_pkg.
module dtq_sqrt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dtq_pkg::sqrt_t in_word,
    output logic           out_valid,
    input  logic           out_ready,
    output dtq_pkg::sqrt_t out_word
);

    logic           valid_reg;
    dtq_pkg::sqrt_t word_reg;
    dtq_pkg::sqrt_t word_next;
    logic [19:0]    trial;
    logic [19:0]    cmp;

    // one digit of the restoring square root
    always_comb
    begin
        trial     = {in_word.rem, in_word.n[31:30]};
        cmp       = {2'b00, in_word.root, 2'b01};
        word_next = in_word;
        word_next.n = {in_word.n[29:0], 2'b00};
        if (trial >= cmp)
        begin
            word_next.rem  = 18'(trial - cmp);
            word_next.root = {in_word.root[14:0], 1'b1};
        end
        else
        begin
            word_next.rem  = trial[17:0];
            word_next.root = {in_word.root[14:0], 1'b0};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // cell valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // cell payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

FILE: rtl/dtq_div_cell.sv
// dtq_div_cell: one quotient bit per cell for each of the three numerator lanes.
// Depends on dtq_pkg.
module dtq_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  dtq_pkg::div_t in_word,
    output logic          out_valid,
    input  logic          out_ready,
    output dtq_pkg::div_t out_word
);

    logic          valid_reg;
    dtq_pkg::div_t word_reg;
    dtq_pkg::div_t word_next;
    logic [dtq_pkg::Lanes-1:0][16:0] part;

    // restoring division step in every lane
    always_comb
    begin
        word_next = in_word;
        for (int i = 0; i < dtq_pkg::Lanes; i++)
        begin
            part[i] = {in_word.rem[i], in_word.dvd[i][29]};
            word_next.dvd[i] = {in_word.dvd[i][28:0], 1'b0};
            if (part[i] >= {1'b0, in_word.root})
            begin
                word_next.rem[i] = 16'(part[i] - {1'b0, in_word.root});
                word_next.quo[i] = {in_word.quo[i][28:0], 1'b1};
            end
            else
            begin
                word_next.rem[i] = part[i][15:0];
                word_next.quo[i] = {in_word.quo[i][28:0], 1'b0};
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // cell valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // cell payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

FILE: rtl/dtq_back.sv
// dtq_back: sign, saturation, component placement and degenerate zeroing, output register.
// Depends on dtq_pkg.
module dtq_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dtq_pkg::div_t      in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output dtq_pkg::out_word_t out_word
);

    logic                       valid_reg;
    dtq_pkg::out_word_t         word_reg;
    dtq_pkg::out_word_t         word_next;
    logic [dtq_pkg::Lanes-1:0][15:0] lane_val;
    logic [15:0]                half_root;
    logic                       degen;

    // signed, saturated quotients
    always_comb
    begin
        for (int i = 0; i < dtq_pkg::Lanes; i++)
        begin
            if (in_word.neg[i])
                lane_val[i] = (in_word.quo[i] > 30'd32768) ? 16'h8000
                                                           : 16'(-in_word.quo[i][15:0]);
            else
                lane_val[i] = (in_word.quo[i] > 30'd32767) ? 16'h7fff
                                                           : in_word.quo[i][15:0];
        end
    end

    assign half_root = {1'b0, in_word.root[15:1]};
    assign degen     = (in_word.root == 16'd0);

    // place components by branch
    always_comb
    begin
        word_next.branch_used = in_word.branch;
        word_next.degenerate  = degen;
        case (in_word.branch)
            dtq_pkg::BR_TRACE:
            begin
                word_next.scalar_part = half_root;
                word_next.vec_x       = lane_val[0];
                word_next.vec_y       = lane_val[1];
                word_next.vec_z       = lane_val[2];
            end
            dtq_pkg::BR_X:
            begin
                word_next.scalar_part = lane_val[0];
                word_next.vec_x       = half_root;
                word_next.vec_y       = lane_val[1];
                word_next.vec_z       = lane_val[2];
            end
            dtq_pkg::BR_Y:
            begin
                word_next.scalar_part = lane_val[0];
                word_next.vec_x       = lane_val[1];
                word_next.vec_y       = half_root;
                word_next.vec_z       = lane_val[2];
            end
            default:
            begin
                word_next.scalar_part = lane_val[0];
                word_next.vec_x       = lane_val[1];
                word_next.vec_y       = lane_val[2];
                word_next.vec_z       = half_root;
            end
        endcase
        if (degen)
        begin
            word_next.scalar_part = '0;
            word_next.vec_x       = '0;
            word_next.vec_y       = '0;
            word_next.vec_z       = '0;
        end
    end

    assign in_ready = !valid_reg || !out_stall;

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

FILE: rtl/dcm_to_quaternion.sv
// dcm_to_quaternion: top level, front stage, chains of root and divider cells, back stage.
// Depends on dtq_pkg, dtq_front, dtq_sqrt_cell, dtq_div_cell, dtq_back.
//
// Usage:
//   matrix channel: one 3x3 Q2.14 rotation matrix per word (matrix, matrix_valid,
//   matrix_stall). quat channel: one Q2.14 quaternion per word with the branch used
//   and a degenerate flag (quat, quat_valid, quat_stall).
//   A word moves on a rising edge with valid high and stall low.
// Pipeline: 1 front stage, 16 square root cells, 30 divider cells, 1 output
//   register, between an accepted matrix and quat_valid.
// Throughput: one word per cycle while quat_stall is low; every cell is a register
//   stage of its own, so a new matrix can enter every cycle while others are in flight.
// Stall: each cell accepts while it is empty or its neighbor takes its word, so
//   bubbles close up; when quat_stall holds the output register, the chain fills
//   and then matrix_stall rises.
// Reset: rst_n low clears all valid bits at once; no words are kept.
module dcm_to_quaternion (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               matrix_valid,
    output logic               matrix_stall,
    input  dtq_pkg::in_word_t  matrix,
    output logic               quat_valid,
    input  logic               quat_stall,
    output dtq_pkg::out_word_t quat
);

    localparam int NS = dtq_pkg::SqrtSteps;
    localparam int ND = dtq_pkg::DivSteps;

    logic                 sq_valid [NS+1];
    logic                 sq_ready [NS+1];
    dtq_pkg::sqrt_t       sq_word  [NS+1];
    logic                 dv_valid [ND+1];
    logic                 dv_ready [ND+1];
    dtq_pkg::div_t        dv_word  [ND+1];
    logic                 front_ready;
    dtq_pkg::sqrt_t       sq_last;

    assign matrix_stall = !front_ready;

    // front stage
    dtq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (matrix_valid),
        .in_ready  (front_ready),
        .in_word   (matrix),
        .out_valid (sq_valid[0]),
        .out_ready (sq_ready[0]),
        .out_word  (sq_word[0])
    );

    // square root cells
    for (genvar g = 0; g < NS; g++)
    begin : g_sqrt
        dtq_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[g]),
            .in_ready  (sq_ready[g]),
            .in_word   (sq_word[g]),
            .out_valid (sq_valid[g+1]),
            .out_ready (sq_ready[g+1]),
            .out_word  (sq_word[g+1])
        );
    end

    // hand the root and numerators over to the divider chain
    assign sq_last          = sq_word[NS];
    assign dv_valid[0]      = sq_valid[NS];
    assign sq_ready[NS]     = dv_ready[0];
    always_comb
    begin
        dv_word[0].branch = sq_last.ctx.branch;
        dv_word[0].neg    = sq_last.ctx.neg;
        dv_word[0].root   = sq_last.root;
        for (int i = 0; i < dtq_pkg::Lanes; i++)
        begin
            dv_word[0].dvd[i] = {sq_last.ctx.mag[i], 13'd0};
            dv_word[0].rem[i] = '0;
            dv_word[0].quo[i] = '0;
        end
    end

    // divider cells
    for (genvar g = 0; g < ND; g++)
    begin : g_div
        dtq_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[g]),
            .in_ready  (dv_ready[g]),
            .in_word   (dv_word[g]),
            .out_valid (dv_valid[g+1]),
            .out_ready (dv_ready[g+1]),
            .out_word  (dv_word[g+1])
        );
    end

    // back stage and output register
    dtq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid[ND]),
        .in_ready  (dv_ready[ND]),
        .in_word   (dv_word[ND]),
        .out_valid (quat_valid),
        .out_stall (quat_stall),
        .out_word  (quat)
    );

endmodule
